### hw/rtl/pmsfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmsfp_pkg
// shared constants and codes for the particulate sensor frame parser
// ----------------------------------------------------------------------------
package pmsfp_pkg;

   localparam int FRAME_LEN = 31;
   localparam int IDX_W     = 5;

   localparam logic [7:0] START_BYTE  = 8'h42;
   localparam logic [7:0] SECOND_BYTE = 8'h4d;

   localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_PM1_HI = IDX_W'(3);
   localparam logic [IDX_W-1:0] IDX_PM1_LO = IDX_W'(4);
   localparam logic [IDX_W-1:0] IDX_PM2_HI = IDX_W'(5);
   localparam logic [IDX_W-1:0] IDX_PM2_LO = IDX_W'(6);
   localparam logic [IDX_W-1:0] IDX_PM10_HI = IDX_W'(7);
   localparam logic [IDX_W-1:0] IDX_PM10_LO = IDX_W'(8);
   localparam logic [IDX_W-1:0] IDX_CSUM_HI = IDX_W'(FRAME_LEN - 2);
   localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_LEN - 1);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SECOND = 2'd1,
      STATUS_BAD_SUM    = 2'd2
   } frame_status_type;

endpackage : pmsfp_pkg
`default_nettype wire

### hw/rtl/pmsfp_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmsfp_req_if / pmsfp_rsp_if
// valid/ready channels for received bytes and parsed frame results
// ----------------------------------------------------------------------------
interface pmsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface : pmsfp_req_if

interface pmsfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pm1_0;
   logic [15:0] pm2_5;
   logic [15:0] pm10;
   logic [1:0]  frame_status;

   modport source (output valid, output pm1_0, output pm2_5, output pm10,
                   output frame_status, input ready);
   modport sink (input valid, input pm1_0, input pm2_5, input pm10,
                 input frame_status, output ready);
endinterface : pmsfp_rsp_if
`default_nettype wire

### hw/rtl/pm_sensor_frame_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pm_sensor_frame_parser_unit
// hunts for 0x42, collects a frame, checks it and reports three pm readings
// ----------------------------------------------------------------------------
// One received byte per beat, one beat per cycle. Bytes are dropped until the
// 0x42 start byte, then the next FRAME_LEN bytes are collected; the first must
// be 0x4d and the last two hold the big-endian checksum of 0x42 plus the other
// collected bytes. On the last byte of a frame one result beat carries the
// PM1.0, PM2.5 and PM10 words and a status (0 ok, 1 bad second start byte,
// 2 checksum mismatch); the words are only meaningful with status 0. Each byte
// is handled in the cycle it is accepted and a result appears in the output
// register on the next cycle. Input is stalled only when a frame's last byte
// is due while an earlier result is still held in the output register.
// ----------------------------------------------------------------------------
module pm_sensor_frame_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   pmsfp_req_if.sink        req_chan,
   pmsfp_rsp_if.source      rsp_chan
);
   import pmsfp_pkg::*;

   logic                 in_frame_ff, in_frame_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [15:0]          sum_ff, sum_in;
   logic                 second_ok_ff, second_ok_in;
   logic [7:0]           csum_hi_ff, csum_hi_in;
   logic [7:0]           pend_hi_ff, pend_hi_in;
   logic [15:0]          pm1_ff, pm1_in;
   logic [15:0]          pm2_ff, pm2_in;
   logic [15:0]          pm10_ff, pm10_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_pm1_ff, rsp_pm2_ff, rsp_pm10_ff;
   frame_status_type     rsp_status_ff;

   logic                 last_due;
   logic                 accept;
   logic                 emit;
   logic [7:0]           rx;
   logic [15:0]          expected;
   frame_status_type     status;

   assign rx       = req_chan.rx_byte;
   assign last_due = in_frame_ff && (idx_ff >= IDX_LAST);
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready || !last_due;
   assign accept   = req_chan.valid && req_chan.ready;
   assign emit     = accept && last_due;
   assign expected = {csum_hi_ff, rx};

   always_comb begin
      priority if (!second_ok_ff) begin
         status = STATUS_BAD_SECOND;
      end else if (sum_ff != expected) begin
         status = STATUS_BAD_SUM;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      in_frame_in  = in_frame_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      second_ok_in = second_ok_ff;
      csum_hi_in   = csum_hi_ff;
      pend_hi_in   = pend_hi_ff;
      pm1_in       = pm1_ff;
      pm2_in       = pm2_ff;
      pm10_in      = pm10_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (rx == START_BYTE) begin
               in_frame_in  = 1'b1;
               idx_in       = IDX_FIRST;
               sum_in       = {8'h00, START_BYTE};
               second_ok_in = 1'b0;
            end
         end else begin
            if (idx_ff == IDX_FIRST) begin
               second_ok_in = (rx == SECOND_BYTE);
            end
            if (idx_ff < IDX_CSUM_HI) begin
               sum_in = sum_ff + {8'h00, rx};
            end else if (idx_ff == IDX_CSUM_HI) begin
               csum_hi_in = rx;
            end
            if (idx_ff == IDX_PM1_HI || idx_ff == IDX_PM2_HI || idx_ff == IDX_PM10_HI) begin
               pend_hi_in = rx;
            end else if (idx_ff == IDX_PM1_LO) begin
               pm1_in = {pend_hi_ff, rx};
            end else if (idx_ff == IDX_PM2_LO) begin
               pm2_in = {pend_hi_ff, rx};
            end else if (idx_ff == IDX_PM10_LO) begin
               pm10_in = {pend_hi_ff, rx};
            end
            if (last_due) begin
               in_frame_in = 1'b0;
               idx_in      = IDX_FIRST;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         idx_ff       <= IDX_FIRST;
         sum_ff       <= 16'h0000;
         second_ok_ff <= 1'b0;
         csum_hi_ff   <= 8'h00;
         pend_hi_ff   <= 8'h00;
         pm1_ff       <= 16'h0000;
         pm2_ff       <= 16'h0000;
         pm10_ff      <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         second_ok_ff <= second_ok_in;
         csum_hi_ff   <= csum_hi_in;
         pend_hi_ff   <= pend_hi_in;
         pm1_ff       <= pm1_in;
         pm2_ff       <= pm2_in;
         pm10_ff      <= pm10_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a beat
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pm1_ff    <= pm1_ff;
         rsp_pm2_ff    <= pm2_ff;
         rsp_pm10_ff   <= pm10_ff;
         rsp_status_ff <= status;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pm1_0        = rsp_pm1_ff;
   assign rsp_chan.pm2_5        = rsp_pm2_ff;
   assign rsp_chan.pm10         = rsp_pm10_ff;
   assign rsp_chan.frame_status = rsp_status_ff;

endmodule : pm_sensor_frame_parser_unit
`default_nettype wire

### sim/tb_pm_sensor_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pm_sensor_frame_parser_unit
// byte-stream testbench for the particulate sensor frame parser
// ----------------------------------------------------------------------------
// A queue of received bytes feeds a valid/ready driver. Well-formed frames
// with random readings make up most of the stream. Mixed in are bad second
// start bytes, checksum errors, cut-off frames and noise between frames.
// Every accepted byte goes through a behavioral frame parser in the bench.
// Each result beat is compared field by field with the oldest expected
// frame. The phases change sender idling and receiver stalls. One phase
// holds the receiver off long enough that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_pm_sensor_frame_parser_unit;
   import pmsfp_pkg::*;

   typedef struct {
      logic [15:0]      pm1_0;
      logic [15:0]      pm2_5;
      logic [15:0]      pm10;
      frame_status_type status;
   } frame_result_type;

   logic clock;
   logic reset;

   pmsfp_req_if req_chan ();
   pmsfp_rsp_if rsp_chan ();

   pm_sensor_frame_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [7:0]       byte_queue [$];
   frame_result_type frame_queue [$];
   frame_result_type want;
   int               err_count    = 0;
   int               tx_idle_pct  = 0;
   int               rx_stall_pct = 0;
   bit               hold_arm     = 1'b0;
   bit               hold_done    = 1'b0;
   int               hold_left    = 0;

   // parser state mirrored in the bench
   bit          collecting;
   logic [4:0]  offset;
   logic [15:0] sum_acc;
   bit          second_ok;
   logic [7:0]  sum_high;
   logic [15:0] pm_word [3];
   logic [7:0]  word_high;

   always #6 clock = ~clock;

   task automatic parse_byte(input logic [7:0] b);
      frame_result_type r;
      logic [15:0]      csum;
      if (!collecting) begin
         if (b == START_BYTE) begin
            collecting = 1'b1;
            offset     = IDX_FIRST;
            sum_acc    = 16'(START_BYTE);
            second_ok  = 1'b0;
         end
      end else begin
         if (offset == IDX_FIRST)
            second_ok = (b == SECOND_BYTE);
         if (offset < IDX_CSUM_HI)
            sum_acc = sum_acc + 16'(b);
         else if (offset == IDX_CSUM_HI)
            sum_high = b;
         case (offset)
            IDX_PM1_HI, IDX_PM2_HI, IDX_PM10_HI: word_high = b;
            IDX_PM1_LO: pm_word[0] = {word_high, b};
            IDX_PM2_LO: pm_word[1] = {word_high, b};
            IDX_PM10_LO: pm_word[2] = {word_high, b};
            default: ;
         endcase
         if (offset >= IDX_LAST) begin
            csum    = {sum_high, b};
            r.pm1_0 = pm_word[0];
            r.pm2_5 = pm_word[1];
            r.pm10  = pm_word[2];
            if (!second_ok)
               r.status = STATUS_BAD_SECOND;
            else if (sum_acc != csum)
               r.status = STATUS_BAD_SUM;
            else
               r.status = STATUS_OK;
            frame_queue.push_back(r);
            collecting = 1'b0;
            offset     = IDX_FIRST;
         end else begin
            offset = offset + 5'd1;
         end
      end
   endtask

   // checker and parser, fed from the two handshakes
   always @(posedge clock) begin
      if (reset) begin
         collecting = 1'b0;
         offset     = IDX_FIRST;
         sum_acc    = 16'd0;
         second_ok  = 1'b0;
         sum_high   = 8'd0;
         word_high  = 8'd0;
         pm_word    = '{default: 16'd0};
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (frame_queue.size() == 0) begin
               $display("%0t: result beat with no frame expected: pm %h %h %h status %0d",
                        $time, rsp_chan.pm1_0, rsp_chan.pm2_5, rsp_chan.pm10,
                        rsp_chan.frame_status);
               err_count++;
            end else begin
               want = frame_queue.pop_front();
               if (rsp_chan.pm1_0 !== want.pm1_0 || rsp_chan.pm2_5 !== want.pm2_5 ||
                   rsp_chan.pm10 !== want.pm10 || rsp_chan.frame_status !== want.status)
                  begin
                  $display("%0t: expected pm %h %h %h st %0d, got pm %h %h %h st %0d",
                           $time, want.pm1_0, want.pm2_5, want.pm10, want.status,
                           rsp_chan.pm1_0, rsp_chan.pm2_5, rsp_chan.pm10,
                           rsp_chan.frame_status);
                  err_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            parse_byte(req_chan.rx_byte);
      end
   end

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.rx_byte <= 8'd0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= byte_queue.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 400;
         hold_done      <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   function automatic logic [15:0] rand_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_frame(input logic [7:0] second, input logic [15:0] w0,
                             input logic [15:0] w1, input logic [15:0] w2,
                             input int fill, input logic [15:0] flip);
      logic [7:0]  body [FRAME_LEN];
      logic [15:0] total;
      body[0] = second;
      for (int i = 1; i < FRAME_LEN - 2; i++)
         body[i] = (fill < 0) ? 8'($urandom) : fill[7:0];
      body[3] = w0[15:8];
      body[4] = w0[7:0];
      body[5] = w1[15:8];
      body[6] = w1[7:0];
      body[7] = w2[15:8];
      body[8] = w2[7:0];
      total = 16'(START_BYTE);
      for (int i = 0; i < FRAME_LEN - 2; i++)
         total = total + 16'(body[i]);
      total = total ^ flip;
      body[FRAME_LEN-2] = total[15:8];
      body[FRAME_LEN-1] = total[7:0];
      byte_queue.push_back(START_BYTE);
      foreach (body[i])
         byte_queue.push_back(body[i]);
   endtask

   task automatic random_frame();
      int          pick;
      logic [7:0]  b;
      logic [7:0]  second;
      logic [15:0] flip;
      // noise between frames, mostly free of start bytes
      repeat ($urandom_range(3)) begin
         b = 8'($urandom);
         if (b == START_BYTE && $urandom_range(3) != 0)
            b = ~b;
         byte_queue.push_back(b);
      end
      pick   = $urandom_range(99);
      second = SECOND_BYTE;
      flip   = 16'd0;
      if ((pick >= 70 && pick < 80) || (pick >= 90 && pick < 95)) begin
         second = 8'($urandom);
         if (second == SECOND_BYTE)
            second = ~second;
      end
      if (pick >= 80 && pick < 95)
         flip = 16'($urandom_range(65535, 1));
      if (pick >= 95) begin
         // cut-off frame, the following bytes finish it
         byte_queue.push_back(START_BYTE);
         byte_queue.push_back(SECOND_BYTE);
         repeat ($urandom_range(20, 1))
            byte_queue.push_back(8'($urandom));
      end else begin
         push_frame(second, rand_word(), rand_word(), rand_word(), -1, flip);
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (byte_queue.size() != 0 || req_chan.valid || frame_queue.size() != 0 ||
             hold_left != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input bit hold,
                            input int frames);
      @(negedge clock);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      hold_arm     = hold;
      repeat (frames)
         random_frame();
      wait_drained();
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'd0;
      rsp_chan.ready   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      @(negedge clock);
      byte_queue.push_back(8'h00);
      byte_queue.push_back(8'hff);
      push_frame(SECOND_BYTE, 16'h0000, 16'h0000, 16'h0000, 0, 16'h0000);
      push_frame(SECOND_BYTE, 16'hffff, 16'hffff, 16'hffff, 255, 16'h0000);
      push_frame(START_BYTE, 16'h1234, 16'h5678, 16'h9abc, START_BYTE, 16'h0000);
      push_frame(8'h00, 16'h0001, 16'h8000, 16'h7fff, -1, 16'h0001);
      push_frame(SECOND_BYTE, 16'h00ff, 16'hff00, 16'h4242, -1, 16'h8000);
      push_frame(SECOND_BYTE, 16'h4242, 16'h0042, 16'h4200, START_BYTE, 16'h0000);
      wait_drained();

      run_phase(0, 0, 1'b0, 4);
      run_phase(75, 0, 1'b0, 4);
      run_phase(0, 75, 1'b0, 4);
      run_phase(20, 20, 1'b0, 4);
      run_phase(0, 0, 1'b1, 4);

      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("** pm_sensor_frame_parser_unit: PASSED **");
      else
         $display("** pm_sensor_frame_parser_unit: FAILED **");
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("** pm_sensor_frame_parser_unit: FAILED **");
      $finish;
   end

endmodule : tb_pm_sensor_frame_parser_unit
